FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent holds in the same cycle
`define HMBD_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hmbd assertion failed");

// consequent holds in the next cycle
`define HMBD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hmbd assertion failed");

`endif

FILE: src/hmbd_pkg.sv
package hmbd_pkg;

	localparam int ADDR_W = 16;
	localparam int DATA_W = 8;

	localparam int VRAM_BYTES = 8192;
	localparam int WRAM_BYTES = 8192;
	localparam int OAM_BYTES  = 'hA0;
	localparam int IO_BYTES   = 128;
	localparam int HRAM_BYTES = 127;
	localparam int DMA_LENGTH = 160;

	localparam int VRAM_AW = $clog2(VRAM_BYTES);
	localparam int WRAM_AW = $clog2(WRAM_BYTES);
	localparam int OAM_AW  = $clog2(OAM_BYTES);
	localparam int IO_AW   = $clog2(IO_BYTES);
	localparam int HRAM_AW = $clog2(HRAM_BYTES);
	localparam int DMA_CW  = $clog2(DMA_LENGTH);

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [ADDR_W-1:0] DIV_ADDR = 16'hFF04;
	localparam logic [ADDR_W-1:0] DMA_ADDR = 16'hFF46;
	localparam logic [ADDR_W-1:0] SC_ADDR  = 16'hFF02;
	localparam logic [ADDR_W-1:0] SB_ADDR  = 16'hFF01;

	localparam logic [DATA_W-1:0] SERIAL_START = 8'h81;
	localparam logic [DATA_W-1:0] UNUSED_DATA  = 8'hFF;

	typedef enum logic [3:0] {
		RGN_CART,
		RGN_VRAM,
		RGN_WRAM,
		RGN_ECHO,
		RGN_OAM,
		RGN_UNUSED,
		RGN_IO,
		RGN_HRAM,
		RGN_IE
	} region_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_DMA_RD,
		ST_DMA_WR,
		ST_RESP
	} state_t;

	function automatic logic is_cart(input logic [ADDR_W-1:0] a);
		return (a <= 16'h7FFF) || (a >= 16'hA000 && a <= 16'hBFFF);
	endfunction

	function automatic region_t decode(input logic [ADDR_W-1:0] a);
		region_t r;
		if (is_cart(a))
			r = RGN_CART;
		else if (a <= 16'h9FFF)
			r = RGN_VRAM;
		else if (a <= 16'hDFFF)
			r = RGN_WRAM;
		else if (a <= 16'hFDFF)
			r = RGN_ECHO;
		else if (a <= 16'hFE9F)
			r = RGN_OAM;
		else if (a <= 16'hFEFF)
			r = RGN_UNUSED;
		else if (a <= 16'hFF7F)
			r = RGN_IO;
		else if (a <= 16'hFFFE)
			r = RGN_HRAM;
		else
			r = RGN_IE;
		return r;
	endfunction

endpackage

FILE: src/handheld_memory_bus_decoder_unit.sv
// channel   signals                                          dir
// request   in_valid in_stall op address write_data           in
//           cart_read_data
// result    out_valid out_stall read_data cart_select          out
//           cart_write dma_external serial_valid serial_byte
//
// A request is accepted in IDLE, passes through EXEC and RESP and then has its
// result registered; no new request is taken before the block is back in IDLE.
// A DMA write adds a DMA_RD and a DMA_WR state per byte copied (read then write
// through the shared bus read path). After reset the block clears all RAMs, one
// entry per cycle, with in_stall high until the last VRAM entry is cleared.
// One request is handled at a time; a new one is taken while a result waits
// under out_stall, and a finished result waits in RESP until the slot frees.
module handheld_memory_bus_decoder_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          op,
	input  logic [hmbd_pkg::ADDR_W-1:0]   address,
	input  logic [hmbd_pkg::DATA_W-1:0]   write_data,
	input  logic [hmbd_pkg::DATA_W-1:0]   cart_read_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [hmbd_pkg::DATA_W-1:0]   read_data,
	output logic                          cart_select,
	output logic                          cart_write,
	output logic                          dma_external,
	output logic                          serial_valid,
	output logic [hmbd_pkg::DATA_W-1:0]   serial_byte
);
	import hmbd_pkg::*;

	logic [DATA_W-1:0] vram [VRAM_BYTES];
	logic [DATA_W-1:0] wram [WRAM_BYTES];
	logic [DATA_W-1:0] oam  [OAM_BYTES];
	logic [DATA_W-1:0] io   [IO_BYTES];
	logic [DATA_W-1:0] hram [HRAM_BYTES];

	state_t state_q, state_d;
	logic [VRAM_AW-1:0] clr_q;
	logic [DMA_CW-1:0]  dma_cnt_q;

	logic              op_q;
	logic [ADDR_W-1:0] addr_q;
	logic [DATA_W-1:0] wdata_q;
	logic [DATA_W-1:0] cdata_q;
	logic [DATA_W-1:0] irq_q;

	region_t           rd_region_q;
	logic [DATA_W-1:0] vram_rd_q, wram_rd_q, oam_rd_q, io_rd_q, hram_rd_q;

	logic              out_valid_q;
	logic [DATA_W-1:0] rdata_q, sbyte_q;
	logic              csel_q, cwr_q, dext_q, sval_q;

	logic              accept, clear_done, dma_last, resp_load, out_take;
	logic              rd_en, wr_en;
	logic [ADDR_W-1:0] rd_addr;
	region_t           rd_region, wr_region;
	logic [DATA_W-1:0] bus_rdata;
	logic              dma_go, dma_ext, serial_go;

	logic                vram_we, wram_we, oam_we, io_we, hram_we;
	logic [VRAM_AW-1:0]  vram_wa;
	logic [WRAM_AW-1:0]  wram_wa;
	logic [OAM_AW-1:0]   oam_wa;
	logic [IO_AW-1:0]    io_wa;
	logic [HRAM_AW-1:0]  hram_wa;
	logic [DATA_W-1:0]   vram_wd, wram_wd, oam_wd, io_wd, hram_wd;

	assign accept     = in_valid && !in_stall;
	assign in_stall   = (state_q != ST_IDLE);
	assign clear_done = (clr_q == VRAM_AW'(VRAM_BYTES - 1));
	assign dma_last   = (dma_cnt_q == DMA_CW'(DMA_LENGTH - 1));
	assign out_take   = out_valid_q && !out_stall;
	assign resp_load  = (state_q == ST_RESP) && (!out_valid_q || !out_stall);
	assign wr_region  = decode(addr_q);
	assign rd_region  = decode(rd_addr);
	assign wr_en      = (state_q == ST_EXEC) && (op_q == OP_WRITE);
	assign dma_ext    = is_cart({wdata_q, 8'h00});
	assign dma_go     = wr_en && (addr_q == DMA_ADDR) && !dma_ext;
	assign serial_go  = (op_q == OP_WRITE) && (addr_q == SC_ADDR) && (wdata_q == SERIAL_START);

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = addr_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clear_done)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept)
					state_d = ST_EXEC;
			end
			ST_EXEC: begin
				rd_en   = 1'b1;
				rd_addr = (op_q == OP_WRITE) ? SB_ADDR : addr_q;
				state_d = dma_go ? ST_DMA_RD : ST_RESP;
			end
			ST_DMA_RD: begin
				rd_en   = 1'b1;
				rd_addr = {wdata_q, 8'h00} + ADDR_W'(dma_cnt_q);
				state_d = ST_DMA_WR;
			end
			ST_DMA_WR: begin
				state_d = dma_last ? ST_RESP : ST_DMA_RD;
			end
			ST_RESP: begin
				if (resp_load)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		case (rd_region_q)
			RGN_CART:             bus_rdata = cdata_q;
			RGN_VRAM:             bus_rdata = vram_rd_q;
			RGN_WRAM, RGN_ECHO:   bus_rdata = wram_rd_q;
			RGN_OAM:              bus_rdata = oam_rd_q;
			RGN_UNUSED:           bus_rdata = UNUSED_DATA;
			RGN_IO:               bus_rdata = io_rd_q;
			RGN_HRAM:             bus_rdata = hram_rd_q;
			default:              bus_rdata = irq_q;
		endcase
	end

	// write ports: clearing pass, request write, DMA fill
	always_comb begin
		vram_we = 1'b0;
		wram_we = 1'b0;
		oam_we  = 1'b0;
		io_we   = 1'b0;
		hram_we = 1'b0;
		vram_wa = addr_q[VRAM_AW-1:0];
		wram_wa = addr_q[WRAM_AW-1:0];
		oam_wa  = addr_q[OAM_AW-1:0];
		io_wa   = addr_q[IO_AW-1:0];
		hram_wa = addr_q[HRAM_AW-1:0];
		vram_wd = wdata_q;
		wram_wd = wdata_q;
		oam_wd  = wdata_q;
		io_wd   = (addr_q == DIV_ADDR) ? '0 : wdata_q;
		hram_wd = wdata_q;
		if (state_q == ST_CLEAR) begin
			vram_we = 1'b1;
			wram_we = 1'b1;
			oam_we  = (clr_q < VRAM_AW'(OAM_BYTES));
			io_we   = (clr_q < VRAM_AW'(IO_BYTES));
			hram_we = (clr_q < VRAM_AW'(HRAM_BYTES));
			vram_wa = clr_q;
			wram_wa = WRAM_AW'(clr_q);
			oam_wa  = OAM_AW'(clr_q);
			io_wa   = IO_AW'(clr_q);
			hram_wa = HRAM_AW'(clr_q);
			vram_wd = '0;
			wram_wd = '0;
			oam_wd  = '0;
			io_wd   = '0;
			hram_wd = '0;
		end else if (state_q == ST_DMA_WR) begin
			oam_we = 1'b1;
			oam_wa = OAM_AW'(dma_cnt_q);
			oam_wd = bus_rdata;
		end else if (wr_en) begin
			vram_we = (wr_region == RGN_VRAM);
			wram_we = (wr_region == RGN_WRAM) || (wr_region == RGN_ECHO);
			oam_we  = (wr_region == RGN_OAM);
			io_we   = (wr_region == RGN_IO);
			hram_we = (wr_region == RGN_HRAM);
		end
	end

	always_ff @(posedge clk) begin
		if (vram_we)
			vram[vram_wa] <= vram_wd;
		if (rd_en && rd_region == RGN_VRAM)
			vram_rd_q <= vram[rd_addr[VRAM_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (wram_we)
			wram[wram_wa] <= wram_wd;
		if (rd_en && (rd_region == RGN_WRAM || rd_region == RGN_ECHO))
			wram_rd_q <= wram[rd_addr[WRAM_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (oam_we)
			oam[oam_wa] <= oam_wd;
		if (rd_en && rd_region == RGN_OAM)
			oam_rd_q <= oam[rd_addr[OAM_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (io_we)
			io[io_wa] <= io_wd;
		if (rd_en && rd_region == RGN_IO)
			io_rd_q <= io[rd_addr[IO_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (hram_we)
			hram[hram_wa] <= hram_wd;
		if (rd_en && rd_region == RGN_HRAM)
			hram_rd_q <= hram[rd_addr[HRAM_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_region_q <= rd_region;
		if (accept) begin
			op_q    <= op;
			addr_q  <= address;
			wdata_q <= write_data;
			cdata_q <= cart_read_data;
		end
		if (resp_load) begin
			rdata_q <= (op_q == OP_READ) ? bus_rdata : '0;
			csel_q  <= is_cart(addr_q);
			cwr_q   <= (op_q == OP_WRITE) && is_cart(addr_q);
			dext_q  <= (op_q == OP_WRITE) && (addr_q == DMA_ADDR) && dma_ext;
			sval_q  <= serial_go;
			sbyte_q <= serial_go ? bus_rdata : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			dma_cnt_q   <= '0;
			irq_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR)
				clr_q <= clr_q + 1'b1;
			if (state_q == ST_EXEC)
				dma_cnt_q <= '0;
			else if (state_q == ST_DMA_WR)
				dma_cnt_q <= dma_cnt_q + 1'b1;
			if (wr_en && wr_region == RGN_IE)
				irq_q <= wdata_q;
			if (resp_load)
				out_valid_q <= 1'b1;
			else if (out_take)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign read_data    = rdata_q;
	assign cart_select  = csel_q;
	assign cart_write   = cwr_q;
	assign dma_external = dext_q;
	assign serial_valid = sval_q;
	assign serial_byte  = sbyte_q;

endmodule

FILE: src/hmbd_checker.sv
`include "assert_macros.svh"

module hmbd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        op,
	input logic [hmbd_pkg::ADDR_W-1:0] address,
	input logic [hmbd_pkg::DATA_W-1:0] write_data,
	input logic [hmbd_pkg::DATA_W-1:0] cart_read_data,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [hmbd_pkg::DATA_W-1:0] read_data,
	input logic                        cart_select,
	input logic                        cart_write,
	input logic                        dma_external,
	input logic                        serial_valid,
	input logic [hmbd_pkg::DATA_W-1:0] serial_byte
);
	import hmbd_pkg::*;

	// one request in flight
	`HMBD_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	`HMBD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`HMBD_ASSERT_SAME(a_cart_write_sel, out_valid && cart_write, cart_select)
	`HMBD_ASSERT_SAME(a_serial_zero, out_valid && !serial_valid, serial_byte == '0)
	`HMBD_ASSERT_SAME(a_dma_not_cart, out_valid && dma_external, !cart_select && !cart_write)

endmodule

bind handheld_memory_bus_decoder_unit hmbd_checker u_hmbd_checker (.*);

FILE: sim/handheld_memory_bus_decoder_unit_checker.sv
module handheld_memory_bus_decoder_unit_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic                        op,
	input  logic [hmbd_pkg::ADDR_W-1:0] address,
	input  logic [hmbd_pkg::DATA_W-1:0] write_data,
	input  logic [hmbd_pkg::DATA_W-1:0] cart_read_data,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [hmbd_pkg::DATA_W-1:0] read_data,
	input  logic                        cart_select,
	input  logic                        cart_write,
	input  logic                        dma_external,
	input  logic                        serial_valid,
	input  logic [hmbd_pkg::DATA_W-1:0] serial_byte,
	output int                          errors,
	output int                          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import hmbd_pkg::*;

	typedef struct packed {
		logic [DATA_W-1:0] rd;
		logic              csel;
		logic              cwr;
		logic              dext;
		logic              sval;
		logic [DATA_W-1:0] sbyte;
	} bus_result_t;

	logic [DATA_W-1:0] vram_img [VRAM_BYTES];
	logic [DATA_W-1:0] wram_img [WRAM_BYTES];
	logic [DATA_W-1:0] oam_img  [OAM_BYTES];
	logic [DATA_W-1:0] io_img   [IO_BYTES];
	logic [DATA_W-1:0] hram_img [HRAM_BYTES];
	logic [DATA_W-1:0] ie_img;

	bus_result_t result_q [$];
	bus_result_t want;
	bus_result_t got;

	function automatic logic cart_space(input logic [ADDR_W-1:0] a);
		return (a <= 16'h7FFF) || (a >= 16'hA000 && a <= 16'hBFFF);
	endfunction

	function automatic region_t region_of(input logic [ADDR_W-1:0] a);
		if (cart_space(a)) return RGN_CART;
		if (a <= 16'h9FFF) return RGN_VRAM;
		if (a <= 16'hDFFF) return RGN_WRAM;
		if (a <= 16'hFDFF) return RGN_ECHO;
		if (a <= 16'hFE9F) return RGN_OAM;
		if (a <= 16'hFEFF) return RGN_UNUSED;
		if (a <= 16'hFF7F) return RGN_IO;
		if (a <= 16'hFFFE) return RGN_HRAM;
		return RGN_IE;
	endfunction

	function automatic logic [DATA_W-1:0] peek(input logic [ADDR_W-1:0] a,
			input logic [DATA_W-1:0] cart_byte);
		logic [DATA_W-1:0] v;
		case (region_of(a))
			RGN_CART:   v = cart_byte;
			RGN_VRAM:   v = vram_img[a - 16'h8000];
			RGN_WRAM:   v = wram_img[a - 16'hC000];
			RGN_ECHO:   v = wram_img[a - 16'hE000];
			RGN_OAM:    v = oam_img[a - 16'hFE00];
			RGN_UNUSED: v = UNUSED_DATA;
			RGN_IO:     v = io_img[a[IO_AW-1:0]];
			RGN_HRAM:   v = hram_img[a - 16'hFF80];
			default:    v = ie_img;
		endcase
		return v;
	endfunction

	function automatic bus_result_t apply_access(input logic kind,
			input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] wd,
			input logic [DATA_W-1:0] cd);
		bus_result_t r;
		logic [ADDR_W-1:0] src;
		r = '0;
		r.csel = cart_space(a);
		if (kind == OP_READ) begin
			r.rd = peek(a, cd);
		end else begin
			case (region_of(a))
				RGN_CART: r.cwr = 1'b1;
				RGN_VRAM: vram_img[a - 16'h8000] = wd;
				RGN_WRAM: wram_img[a - 16'hC000] = wd;
				RGN_ECHO: wram_img[a - 16'hE000] = wd;
				RGN_OAM:  oam_img[a - 16'hFE00] = wd;
				RGN_UNUSED: ;
				RGN_IO: begin
					if (a == DIV_ADDR) begin
						io_img[a[IO_AW-1:0]] = '0;
					end else begin
						io_img[a[IO_AW-1:0]] = wd;
						if (a == DMA_ADDR) begin
							src = {wd, 8'h00};
							if (cart_space(src)) begin
								r.dext = 1'b1;
							end else begin
								for (int i = 0; i < DMA_LENGTH; i++)
									oam_img[i] = peek(src + i[ADDR_W-1:0], 8'h00);
							end
						end
						if (a == SC_ADDR && wd == SERIAL_START) begin
							r.sval  = 1'b1;
							r.sbyte = io_img[SB_ADDR[IO_AW-1:0]];
						end
					end
				end
				RGN_HRAM: hram_img[a - 16'hFF80] = wd;
				default:  ie_img = wd;
			endcase
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [DATA_W-1:0] exp_v,
			input logic [DATA_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
				$time, name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VRAM_BYTES; i++) vram_img[i] = '0;
			for (int i = 0; i < WRAM_BYTES; i++) wram_img[i] = '0;
			for (int i = 0; i < OAM_BYTES; i++) oam_img[i] = '0;
			for (int i = 0; i < IO_BYTES; i++) io_img[i] = '0;
			for (int i = 0; i < HRAM_BYTES; i++) hram_img[i] = '0;
			ie_img = '0;
			result_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = '{read_data, cart_select, cart_write, dma_external,
					serial_valid, serial_byte};
				if (result_q.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual 0x%0h",
						$time, got);
					errors++;
				end else begin
					want = result_q.pop_front();
					check_field("read_data", want.rd, got.rd);
					check_field("cart_select", want.csel, got.csel);
					check_field("cart_write", want.cwr, got.cwr);
					check_field("dma_external", want.dext, got.dext);
					check_field("serial_valid", want.sval, got.sval);
					check_field("serial_byte", want.sbyte, got.sbyte);
				end
			end
			if (in_valid && !in_stall)
				result_q.push_back(apply_access(op, address, write_data, cart_read_data));
			pending = result_q.size();
		end
	end

endmodule

FILE: sim/handheld_memory_bus_decoder_unit_test.sv
module handheld_memory_bus_decoder_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import hmbd_pkg::*;

	localparam int RANDOM_ITEMS = 1850;
	localparam int MAX_GAP      = 60;
	localparam int DRAIN_CYCLES = 400;
	localparam int LIMIT = 2 * 8192 + (RANDOM_ITEMS + 50) * (330 + 2 * MAX_GAP) * 3;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic              op;
	logic [ADDR_W-1:0] address;
	logic [DATA_W-1:0] write_data;
	logic [DATA_W-1:0] cart_read_data;
	logic              out_valid;
	logic              out_stall;
	logic [DATA_W-1:0] read_data;
	logic              cart_select;
	logic              cart_write;
	logic              dma_external;
	logic              serial_valid;
	logic [DATA_W-1:0] serial_byte;

	int errors;
	int pending;
	int cycles = 0;
	int sent_items;
	int stall_left;
	bit calm;

	handheld_memory_bus_decoder_unit u_top (
		.clk, .arst_n, .in_valid, .in_stall, .op, .address, .write_data,
		.cart_read_data, .out_valid, .out_stall, .read_data, .cart_select,
		.cart_write, .dma_external, .serial_valid, .serial_byte
	);

	handheld_memory_bus_decoder_unit_checker u_checker (
		.clk, .arst_n, .in_valid, .in_stall, .op, .address, .write_data,
		.cart_read_data, .out_valid, .out_stall, .read_data, .cart_select,
		.cart_write, .dma_external, .serial_valid, .serial_byte,
		.errors, .pending
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("handheld_memory_bus_decoder_unit_test: errors");
			$finish;
		end
	end

	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, MAX_GAP);
	endfunction

	// result-side backpressure
	always @(negedge clk) begin
		if (!arst_n || calm) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 9) < 3) begin
			out_stall  <= 1'b1;
			stall_left <= idle_length();
		end else begin
			out_stall <= 1'b0;
		end
	end

	function automatic logic [DATA_W-1:0] pick_byte();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			2: return SERIAL_START;
			default: return DATA_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [ADDR_W-1:0] pick_in(input int lo, input int hi);
		case ($urandom_range(0, 3))
			0, 1: return ADDR_W'(lo + $urandom_range(0, 15));
			2: return ADDR_W'(hi - $urandom_range(0, 15));
			default: return ADDR_W'($urandom_range(lo, hi));
		endcase
	endfunction

	function automatic logic [ADDR_W-1:0] pick_addr();
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 1) ? pick_in(16'h0000, 16'h7FFF)
				: pick_in(16'hA000, 16'hBFFF);
			1: return pick_in(16'h8000, 16'h9FFF);
			2: return pick_in(16'hC000, 16'hDFFF);
			3: return pick_in(16'hE000, 16'hFDFF);
			4: return pick_in(16'hFE00, 16'hFE9F);
			5: return pick_in(16'hFEA0, 16'hFEFF);
			6, 7: return pick_in(16'hFF00, 16'hFF7F);
			8: return pick_in(16'hFF80, 16'hFFFE);
			default: return 16'hFFFF;
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_page();
		case ($urandom_range(0, 9))
			0: return DATA_W'($urandom_range(8'h00, 8'h7F));
			1: return DATA_W'($urandom_range(8'hA0, 8'hBF));
			2: return DATA_W'($urandom_range(8'h80, 8'h9F));
			3, 4: return DATA_W'($urandom_range(8'hC0, 8'hDF));
			5: return DATA_W'($urandom_range(8'hE0, 8'hFD));
			6: return 8'hFE;
			7: return 8'hFF;
			8: return 8'h80;
			default: return 8'hC0;
		endcase
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_request(input logic kind, input logic [ADDR_W-1:0] a,
			input logic [DATA_W-1:0] wd);
		int gap;
		gap = idle_length();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		op             <= kind;
		address        <= a;
		write_data     <= wd;
		cart_read_data <= DATA_W'($urandom_range(0, 255));
		in_valid       <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent_items++;
		@(negedge clk);
	endtask

	initial begin
		logic [DATA_W-1:0] page;
		logic [DATA_W-1:0] d;
		logic [ADDR_W-1:0] a;
		int n;

		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		op             <= OP_READ;
		address        <= '0;
		write_data     <= '0;
		cart_read_data <= '0;
		sent_items     = 0;
		calm           = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_request(OP_READ, 16'h0000, 8'h00);
		send_request(OP_WRITE, 16'h7FFF, 8'h5A);
		send_request(OP_WRITE, 16'hA000, 8'hC3);
		send_request(OP_READ, 16'hBFFF, 8'h00);
		send_request(OP_WRITE, 16'h8000, 8'h11);
		send_request(OP_READ, 16'h8000, 8'h00);
		send_request(OP_WRITE, 16'h9FFF, 8'hEE);
		send_request(OP_WRITE, 16'hC000, 8'h22);
		send_request(OP_READ, 16'hE000, 8'h00);
		send_request(OP_WRITE, 16'hFDFF, 8'h77);
		send_request(OP_READ, 16'hDDFF, 8'h00);
		send_request(OP_WRITE, 16'hFE00, 8'h99);
		send_request(OP_WRITE, 16'hFEA0, 8'h55);
		send_request(OP_READ, 16'hFEFF, 8'h00);
		send_request(OP_WRITE, DIV_ADDR, 8'hAB);
		send_request(OP_READ, DIV_ADDR, 8'h00);
		send_request(OP_WRITE, SB_ADDR, 8'hA5);
		send_request(OP_WRITE, SC_ADDR, SERIAL_START);
		send_request(OP_WRITE, SC_ADDR, 8'h80);
		send_request(OP_WRITE, 16'hFFFE, 8'hFE);
		send_request(OP_WRITE, 16'hFFFF, 8'hFF);
		send_request(OP_READ, 16'hFFFF, 8'h00);
		send_request(OP_WRITE, DMA_ADDR, 8'hC0);
		send_request(OP_READ, 16'hFE00, 8'h00);
		send_request(OP_WRITE, DMA_ADDR, 8'h00);

		while (sent_items < RANDOM_ITEMS + 25) begin
			if ($urandom_range(0, 79) == 0) calm = !calm;
			case ($urandom_range(0, 19))
				0, 1: send_request(1'($urandom_range(0, 1)),
					ADDR_W'($urandom_range(0, 16'hFFFF)), DATA_W'($urandom_range(0, 255)));
				2, 3, 4: begin
					a = pick_addr();
					send_request(OP_WRITE, a, pick_byte());
					send_request(OP_READ, a, 8'h00);
				end
				5, 6: begin
					send_request(OP_WRITE, SB_ADDR, pick_byte());
					d = $urandom_range(0, 3) != 0 ? SERIAL_START : pick_byte();
					send_request(OP_WRITE, SC_ADDR, d);
					if ($urandom_range(0, 1)) send_request(OP_READ, SC_ADDR, 8'h00);
				end
				7: begin
					page = pick_page();
					if (page inside {[8'h80 : 8'h9F], [8'hC0 : 8'hFD]}) begin
						n = $urandom_range(1, 4);
						repeat (n)
							send_request(OP_WRITE,
								{page, DATA_W'($urandom_range(0, DMA_LENGTH - 1))},
								pick_byte());
					end
					send_request(OP_WRITE, DMA_ADDR, page);
					n = $urandom_range(1, 3);
					repeat (n)
						send_request(OP_READ,
							16'hFE00 + ADDR_W'($urandom_range(0, DMA_LENGTH - 1)), 8'h00);
				end
				8, 9: send_request(1'($urandom_range(0, 1)),
					DIV_ADDR, pick_byte());
				default: send_request(1'($urandom_range(0, 1)),
					pick_addr(), pick_byte());
			endcase
		end
		in_valid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("handheld_memory_bus_decoder_unit_test: clean");
		else
			$display("handheld_memory_bus_decoder_unit_test: errors");
		$finish;
	end

endmodule
